[hdl/block_cache_lru_writeback_assert.svh]
// Assertion macros for the buffer cache controller.
// BCLW_ASSERT: property checked at every rising clock edge outside reset.
// BCLW_ASSERT_NEXT: when the first argument holds, the second holds in the next cycle.
`ifndef BLOCK_CACHE_LRU_WRITEBACK_ASSERT_SVH
`define BLOCK_CACHE_LRU_WRITEBACK_ASSERT_SVH
`ifndef SYNTHESIS
`define BCLW_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("bclw assertion failed");
`define BCLW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bclw assertion failed");
`else
`define BCLW_ASSERT(label, clk, rstn, prop)
`define BCLW_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

[hdl/bclw_pkg.sv]
package bclw_pkg;

    localparam int NUM_BUFFERS_DEF = 32;
    localparam int Q_DEPTH         = 2;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_MARK  = 2'd2;
    localparam logic [1:0] OP_SYNC  = 2'd3;

    localparam logic [1:0] KIND_WB    = 2'd0;
    localparam logic [1:0] KIND_FETCH = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_ERR   = 2'd3;

    localparam logic REG_INVALID_BNO = 1'b0;
    localparam logic REG_FLAG_MASK   = 1'b1;

    localparam logic [31:0] INVALID_BNO_RST = 32'hFFFF_FFFF;
    localparam logic [31:0] FLAG_MASK_RST   = 32'h8000_0000;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] block_number;
        logic [5:0]  slot;
    } in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] block_number_res;
        logic [5:0]  slot_res;
        logic        last;
    } res_t;

    // classified command handed from front to back
    typedef struct packed {
        logic [1:0]  op;
        logic        err;
        logic [31:0] bno;   // masked tag, or raw number on error
        logic [5:0]  slot;
    } cmd_t;

endpackage

[hdl/bclw_front.sv]
module bclw_front #(
    parameter int NUM_BUFFERS = bclw_pkg::NUM_BUFFERS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bclw_pkg::in_t      s_data,
    input  logic               cfg_wr_en,
    input  logic               cfg_addr,
    input  logic [31:0]        cfg_wr_data,
    output logic               q_valid,
    input  logic               q_ready,
    output bclw_pkg::cmd_t     q_cmd
);
    localparam int PTR_W = (bclw_pkg::Q_DEPTH > 1) ? $clog2(bclw_pkg::Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(bclw_pkg::Q_DEPTH + 1);

    logic [31:0] inv_bno_reg;
    logic [31:0] mask_reg;
    bclw_pkg::cmd_t q_mem [bclw_pkg::Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    bclw_pkg::cmd_t cmd_new;
    logic push, pop;

    always_comb begin
        cmd_new.op   = s_data.op;
        cmd_new.slot = s_data.slot;
        cmd_new.err  = 1'b0;
        if (s_data.op == bclw_pkg::OP_ALLOC || s_data.op == bclw_pkg::OP_READ) begin
            cmd_new.err = (s_data.block_number == inv_bno_reg);
        end else if (s_data.op == bclw_pkg::OP_MARK) begin
            cmd_new.err = (s_data.slot >= 6'(NUM_BUFFERS));
        end
        cmd_new.bno = cmd_new.err ? s_data.block_number : (s_data.block_number & ~mask_reg);
    end

    assign s_ready = (cnt_reg < CNT_W'(bclw_pkg::Q_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_cmd   = q_mem[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_bno_reg <= bclw_pkg::INVALID_BNO_RST;
            mask_reg    <= bclw_pkg::FLAG_MASK_RST;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            cnt_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == bclw_pkg::REG_INVALID_BNO) begin
                    inv_bno_reg <= cfg_wr_data;
                end else begin
                    mask_reg <= cfg_wr_data;
                end
            end
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(bclw_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(bclw_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= cmd_new;
        end
    end

endmodule

[hdl/bclw_back.sv]
`include "block_cache_lru_writeback_assert.svh"

module bclw_back #(
    parameter int NUM_BUFFERS = bclw_pkg::NUM_BUFFERS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_ready,
    input  bclw_pkg::cmd_t     q_cmd,
    output logic               m_valid,
    input  logic               m_ready,
    output bclw_pkg::res_t     m_data
);
    localparam int IDX_W = $clog2(NUM_BUFFERS);
    localparam int CNT_W = $clog2(NUM_BUFFERS + 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SEARCH = 4'd1;
    localparam logic [3:0] ST_PICK   = 4'd2;
    localparam logic [3:0] ST_LMATCH = 4'd3;
    localparam logic [3:0] ST_LSHIFT = 4'd4;
    localparam logic [3:0] ST_FLUSH  = 4'd5;
    localparam logic [3:0] ST_FETCH  = 4'd6;
    localparam logic [3:0] ST_DONE   = 4'd7;
    localparam logic [3:0] ST_ERR    = 4'd8;

    logic [3:0]             state_reg, state_next;
    bclw_pkg::cmd_t         cmd_reg;
    logic [31:0]            tags_reg [NUM_BUFFERS];
    logic [NUM_BUFFERS-1:0] valid_reg, dirty_reg;
    logic [IDX_W-1:0]       lru_reg  [NUM_BUFFERS];
    logic [IDX_W-1:0]       fifo_reg [NUM_BUFFERS];
    logic [IDX_W-1:0]       head_reg, tail_reg, tgt_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [NUM_BUFFERS-1:0] hit_vec_reg, lmask_reg, hv, ge;
    logic                   hit_reg, was_dirty_reg, all_reg;
    logic                   out_valid_reg;
    bclw_pkg::res_t         out_data_reg, emit_data;
    logic                   emit, out_free, need_fetch, flush_last;
    logic [IDX_W-1:0]       head_slot, rd_idx, enc, pick_tgt;
    logic [31:0]            rd_tag;
    logic [3:0]             after_flush;

    assign out_free   = !out_valid_reg || m_ready;
    assign head_slot  = fifo_reg[head_reg];
    assign rd_idx     = (state_reg == ST_FLUSH) ? head_slot : tgt_reg;
    assign rd_tag     = tags_reg[rd_idx];
    assign need_fetch = (cmd_reg.op == bclw_pkg::OP_READ) && !hit_reg;
    assign flush_last = (cnt_reg == CNT_W'(1)) || (!all_reg && head_slot == tgt_reg);
    assign after_flush = need_fetch ? ST_FETCH : ST_DONE;
    assign pick_tgt   = (cmd_reg.op == bclw_pkg::OP_MARK) ? cmd_reg.slot[IDX_W-1:0] :
                        (hit_reg ? enc : lru_reg[0]);
    assign m_valid    = out_valid_reg;
    assign m_data     = out_data_reg;

    // tag compare and first-hit encode
    always_comb begin
        enc = '0;
        for (int i = 0; i < NUM_BUFFERS; i++) begin
            hv[i] = valid_reg[i] && (tags_reg[i] == cmd_reg.bno);
        end
        for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
            if (hit_vec_reg[i]) begin
                enc = IDX_W'(i);
            end
        end
    end

    // positions at or above the touched slot
    always_comb begin
        ge[0] = lmask_reg[0];
        for (int i = 1; i < NUM_BUFFERS; i++) begin
            ge[i] = ge[i-1] | lmask_reg[i];
        end
    end

    always_comb begin
        state_next = state_reg;
        emit       = 1'b0;
        emit_data  = '0;
        q_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    if (q_cmd.err) begin
                        state_next = ST_ERR;
                    end else begin
                        case (q_cmd.op)
                            bclw_pkg::OP_ALLOC, bclw_pkg::OP_READ: state_next = ST_SEARCH;
                            bclw_pkg::OP_MARK: state_next = ST_PICK;
                            default: state_next = (cnt_reg != '0) ? ST_FLUSH : ST_DONE;
                        endcase
                    end
                end
            end
            ST_SEARCH: state_next = ST_PICK;
            ST_PICK:   state_next = ST_LMATCH;
            ST_LMATCH: state_next = ST_LSHIFT;
            ST_LSHIFT: state_next = was_dirty_reg ? ST_FLUSH : after_flush;
            ST_FLUSH: begin
                if (cnt_reg == '0) begin
                    state_next = after_flush;
                end else if (out_free) begin
                    emit      = 1'b1;
                    emit_data = '{kind: bclw_pkg::KIND_WB, block_number_res: rd_tag,
                                  slot_res: 6'(head_slot), last: 1'b0};
                    if (flush_last) begin
                        state_next = after_flush;
                    end
                end
            end
            ST_FETCH: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_data  = '{kind: bclw_pkg::KIND_FETCH, block_number_res: cmd_reg.bno,
                                   slot_res: 6'(tgt_reg), last: 1'b0};
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    emit_data.kind = bclw_pkg::KIND_DONE;
                    emit_data.last = 1'b1;
                    case (cmd_reg.op)
                        bclw_pkg::OP_SYNC: begin
                            emit_data.block_number_res = '0;
                            emit_data.slot_res         = '0;
                        end
                        bclw_pkg::OP_MARK: begin
                            emit_data.block_number_res = valid_reg[tgt_reg] ? rd_tag : '0;
                            emit_data.slot_res         = 6'(tgt_reg);
                        end
                        default: begin
                            emit_data.block_number_res = cmd_reg.bno;
                            emit_data.slot_res         = 6'(tgt_reg);
                        end
                    endcase
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    emit_data.kind = bclw_pkg::KIND_ERR;
                    emit_data.last = 1'b1;
                    if (cmd_reg.op == bclw_pkg::OP_MARK) begin
                        emit_data.block_number_res = '0;
                        emit_data.slot_res         = cmd_reg.slot;
                    end else begin
                        emit_data.block_number_res = cmd_reg.bno;
                        emit_data.slot_res         = '0;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_BUFFERS; i++) begin
                lru_reg[i] <= IDX_W'(i);
            end
        end else begin
            state_reg <= state_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_LSHIFT) begin
                for (int i = 0; i < NUM_BUFFERS - 1; i++) begin
                    lru_reg[i] <= ge[i] ? lru_reg[i+1] : lru_reg[i];
                end
                lru_reg[NUM_BUFFERS-1] <= tgt_reg;
            end
            if (state_reg == ST_FLUSH && emit) begin
                dirty_reg[head_slot] <= 1'b0;
                head_reg <= (head_reg == IDX_W'(NUM_BUFFERS - 1)) ? '0 : head_reg + 1'b1;
                cnt_reg  <= cnt_reg - 1'b1;
            end
            if (state_reg == ST_DONE && emit) begin
                if (cmd_reg.op == bclw_pkg::OP_ALLOC || cmd_reg.op == bclw_pkg::OP_READ) begin
                    valid_reg[tgt_reg] <= 1'b1;
                end
                if (cmd_reg.op == bclw_pkg::OP_MARK && !was_dirty_reg) begin
                    dirty_reg[tgt_reg] <= 1'b1;
                    tail_reg <= (tail_reg == IDX_W'(NUM_BUFFERS - 1)) ? '0 : tail_reg + 1'b1;
                    cnt_reg  <= cnt_reg + 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && q_valid) begin
            cmd_reg <= q_cmd;
            all_reg <= (q_cmd.op == bclw_pkg::OP_SYNC);
        end
        if (state_reg == ST_SEARCH) begin
            hit_vec_reg <= hv;
            hit_reg     <= |hv;
        end
        if (state_reg == ST_PICK) begin
            tgt_reg       <= pick_tgt;
            was_dirty_reg <= dirty_reg[pick_tgt];
        end
        if (state_reg == ST_LMATCH) begin
            for (int i = 0; i < NUM_BUFFERS; i++) begin
                lmask_reg[i] <= (lru_reg[i] == tgt_reg);
            end
        end
        if (state_reg == ST_DONE && emit) begin
            if (cmd_reg.op == bclw_pkg::OP_ALLOC || cmd_reg.op == bclw_pkg::OP_READ) begin
                tags_reg[tgt_reg] <= cmd_reg.bno;
            end
            if (cmd_reg.op == bclw_pkg::OP_MARK && !was_dirty_reg) begin
                fifo_reg[tail_reg] <= tgt_reg;
            end
        end
        if (emit) begin
            out_data_reg <= emit_data;
        end
    end

    `BCLW_ASSERT(a_cnt_tracks_dirty, aclk, aresetn, $countones(dirty_reg) == int'(cnt_reg))
    `BCLW_ASSERT(a_cnt_bound, aclk, aresetn, int'(cnt_reg) <= NUM_BUFFERS)
    `BCLW_ASSERT_NEXT(a_done_to_idle, aclk, aresetn, state_reg == ST_DONE && out_free, state_reg == ST_IDLE && out_valid_reg && out_data_reg.last)

endmodule

[hdl/block_cache_lru_writeback.sv]
// Channel    | Ports                       | Word
// -----------+-----------------------------+------------------------------------
// op in      | s_valid s_ready s_data      | op, block_number, slot
// result out | m_valid m_ready m_data      | kind, block_number_res, slot_res, last
// config     | cfg_wr_en cfg_addr cfg_wr_data | 0 reserved block, 1 flag mask
//
// Allocate/read: tag search, pick, LRU match then shift, then any write-backs,
// a fetch on a read miss and the reply word; mark dirty skips the search, sync
// flushes every dirty slot and replies. Output is one word per cycle while
// m_ready allows; a reply held by m_ready stalls the back end.
// Reset (aresetn low, synchronous) clears valid/dirty bits, the dirty queue
// and sets LRU order to slot 0 oldest. A two-word queue lets ops arrive while
// the back end is stalled on m_ready.
module block_cache_lru_writeback #(
    parameter int NUM_BUFFERS = bclw_pkg::NUM_BUFFERS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  bclw_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output bclw_pkg::res_t m_data,
    input  logic           cfg_wr_en,
    input  logic           cfg_addr,
    input  logic [31:0]    cfg_wr_data
);
    logic           q_valid, q_ready;
    bclw_pkg::cmd_t q_cmd;

    // front: config registers, reserved-number/slot checks, tag masking, queue
    bclw_front #(.NUM_BUFFERS(NUM_BUFFERS)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_cmd       (q_cmd)
    );

    // back: tag lookup, LRU, dirty queue flush, registered output word
    bclw_back #(.NUM_BUFFERS(NUM_BUFFERS)) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
